[hdl/ptc_pkg.sv]
// Shared types and constants of the pressure and temperature compensation pipeline.
package ptc_pkg;

  localparam int unsigned CoeffW   = 16;
  localparam int unsigned RawW     = 24;
  localparam int unsigned OutW     = 32;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned NStages  = 9;

  // Calibration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    RegSens     = 3'd0,
    RegOffset   = 3'd1,
    RegTcs      = 3'd2,
    RegTco      = 3'd3,
    RegTref     = 3'd4,
    RegTempsens = 3'd5
  } ptc_reg_e;

  typedef struct packed {
    logic [CoeffW-1:0] sens;
    logic [CoeffW-1:0] offset;
    logic [CoeffW-1:0] tcs;
    logic [CoeffW-1:0] tco;
    logic [CoeffW-1:0] tref;
    logic [CoeffW-1:0] tempsens;
  } ptc_coeff_t;

endpackage

[hdl/ptc_regs.sv]
// Calibration register file of the compensation unit.
module ptc_regs
  import ptc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CoeffW-1:0]   cfg_data_i,
  output ptc_coeff_t          coeff_o
);

  ptc_coeff_t coeff_q, coeff_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    coeff_d = coeff_q;
    if (cfg_valid_i) begin
      unique case (ptc_reg_e'(cfg_addr_i))
        RegSens:     coeff_d.sens     = cfg_data_i;
        RegOffset:   coeff_d.offset   = cfg_data_i;
        RegTcs:      coeff_d.tcs      = cfg_data_i;
        RegTco:      coeff_d.tco      = cfg_data_i;
        RegTref:     coeff_d.tref     = cfg_data_i;
        RegTempsens: coeff_d.tempsens = cfg_data_i;
        default:     coeff_d = coeff_q;  // drop writes beyond the list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= '0;
    end else begin
      coeff_q <= coeff_d;
    end
  end

  assign coeff_o = coeff_q;

endmodule

[hdl/pressure_temp_compensation_unit.sv]
// Top level: nine-stage second-order pressure and temperature compensation pipeline.
//
//  channel  | valid / ready              | payload
//  ---------+----------------------------+----------------------------------
//  cfg      | cfg_valid_i / cfg_ready_o  | cfg_addr_i, cfg_data_i
//  input    | in_valid_i / in_ready_o    | pressure_raw_i, temp_raw_i
//  output   | out_valid_o / out_ready_i  | pressure_o, temperature_o
//
// One sample pair enters per cycle unless the output stalls; each result runs
// through the nine register stages (dT, products, first order, squares, corrections,
// corrected terms, split sensitivity product, product sum, output register).
// Reset clears the valid bits and the calibration words. A stall on the output
// freezes every stage at once; in_ready_o is low only while a result waits.
module pressure_temp_compensation_unit
  import ptc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgAddrW-1:0]    cfg_addr_i,
  input  logic [CoeffW-1:0]      cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [RawW-1:0]        pressure_raw_i,
  input  logic [RawW-1:0]        temp_raw_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [OutW-1:0] pressure_o,
  output logic signed [OutW-1:0] temperature_o
);

  ptc_coeff_t coeff;

  ptc_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .coeff_o     (coeff)
  );

  logic               pipe_en;
  logic [NStages-1:0] vld_q, vld_d;

  assign pipe_en    = !vld_q[NStages-1] || out_ready_i;
  assign in_ready_o = pipe_en;

  assign vld_d = {vld_q[NStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= vld_d;
    end
  end

  // Stage 0: temperature difference
  logic signed [24:0]    s0_dt_q, s0_dt_d;
  logic [RawW-1:0]       s0_d1_q;
  // Stage 1: products with dT
  logic signed [41:0]    s1_pts_q, s1_pts_d;
  logic signed [41:0]    s1_ptco_q, s1_ptco_d;
  logic signed [41:0]    s1_ptcs_q, s1_ptcs_d;
  logic signed [49:0]    s1_dtsq_full;
  logic [47:0]           s1_dtsq_q;
  logic [RawW-1:0]       s1_d1_q;
  // Stage 2: first-order terms
  logic signed [17:0]    s2_dtemp_q, s2_dtemp_d;
  logic signed [18:0]    s2_lo_q, s2_lo_d;
  logic signed [39:0]    s2_off_q, s2_off_d;
  logic signed [39:0]    s2_sens_q, s2_sens_d;
  logic [16:0]           s2_t2_q, s2_t2_d;
  logic [50:0]           s2_dt7;
  logic [49:0]           s2_dt3;
  logic [RawW-1:0]       s2_d1_q;
  // Stage 3: squares and final temperature
  logic signed [35:0]    s3_sq_full;
  logic signed [37:0]    s3_lsq_full;
  logic [34:0]           s3_sq_q, s3_lsq_q;
  logic signed [19:0]    s3_temp_q, s3_temp_d;
  logic                  s3_low_q, s3_cold_q;
  logic signed [39:0]    s3_off_q, s3_sens_q;
  logic [RawW-1:0]       s3_d1_q;
  // Stage 4: second-order corrections
  logic [39:0]           s4_off2_q, s4_off2_d;
  logic [39:0]           s4_sens2_q, s4_sens2_d;
  logic [36:0]           s4_sq3, s4_sq5;
  logic [37:0]           s4_lsq7;
  logic [36:0]           s4_lsq4;
  logic signed [19:0]    s4_temp_q;
  logic signed [39:0]    s4_off_q, s4_sens_q;
  logic [RawW-1:0]       s4_d1_q;
  // Stage 5: corrected offset and sensitivity
  logic signed [39:0]    s5_offc_q, s5_sensc_q;
  logic signed [19:0]    s5_temp_q;
  logic [RawW-1:0]       s5_d1_q;
  // Stage 6: split sensitivity product
  logic [43:0]           s6_plo_q;
  logic signed [44:0]    s6_phi_q, s6_phi_d;
  logic signed [39:0]    s6_offc_q;
  logic signed [19:0]    s6_temp_q;
  // Stage 7: full product
  logic signed [63:0]    s7_prod_q, s7_prod_d;
  logic signed [39:0]    s7_offc_q;
  logic signed [19:0]    s7_temp_q;
  // Stage 8: output
  logic signed [42:0]    s8_sh;
  logic signed [43:0]    s8_diff;
  logic signed [OutW-1:0] s8_pres_q, s8_pres_d;
  logic signed [OutW-1:0] s8_temp_q;

  always_comb begin
    s0_dt_d = $signed({1'b0, temp_raw_i}) - $signed({1'b0, coeff.tref, 8'h00});

    s1_pts_d     = s0_dt_q * $signed({1'b0, coeff.tempsens});
    s1_ptco_d    = s0_dt_q * $signed({1'b0, coeff.tco});
    s1_ptcs_d    = s0_dt_q * $signed({1'b0, coeff.tcs});
    s1_dtsq_full = s0_dt_q * s0_dt_q;

    // slicing the signed product floors like an arithmetic shift
    s2_dtemp_d = s1_pts_q[40:23];
    s2_lo_d    = $signed({s2_dtemp_d[17], s2_dtemp_d}) + 19'sd3500;
    s2_off_d   = $signed({8'h00, coeff.offset, 16'h0000}) + 40'(s1_ptco_q >>> 7);
    s2_sens_d  = $signed({9'h000, coeff.sens, 15'h0000}) + 40'(s1_ptcs_q >>> 8);
    s2_dt7     = {s1_dtsq_q, 3'b000} - {3'b000, s1_dtsq_q};
    s2_dt3     = {s1_dtsq_q, 1'b0} + {2'b00, s1_dtsq_q};
    s2_t2_d    = s2_dtemp_d[17] ? s2_dt3[49:33] : {3'b000, s2_dt7[50:37]};

    s3_sq_full  = s2_dtemp_q * s2_dtemp_q;
    s3_lsq_full = s2_lo_q * s2_lo_q;
    s3_temp_d   = $signed({{2{s2_dtemp_q[17]}}, s2_dtemp_q}) + 20'sd2000
                  - $signed({3'b000, s2_t2_q});

    s4_sq3  = {s3_sq_q, 1'b0} + {2'b00, s3_sq_q};
    s4_sq5  = {s3_sq_q, 2'b00} + {2'b00, s3_sq_q};
    s4_lsq7 = {s3_lsq_q, 3'b000} - {3'b000, s3_lsq_q};
    s4_lsq4 = {s3_lsq_q, 2'b00};
    if (!s3_low_q) begin
      s4_off2_d  = {9'h000, s3_sq_q[34:4]};
      s4_sens2_d = '0;
    end else if (s3_cold_q) begin
      s4_off2_d  = {4'h0, s4_sq3[36:1]} + {2'b00, s4_lsq7};
      s4_sens2_d = {6'h00, s4_sq5[36:3]} + {3'b000, s4_lsq4};
    end else begin
      s4_off2_d  = {4'h0, s4_sq3[36:1]};
      s4_sens2_d = {6'h00, s4_sq5[36:3]};
    end

    s6_phi_d = $signed(s5_sensc_q[39:20]) * $signed({1'b0, s5_d1_q});

    s7_prod_d = $signed(64'({s6_phi_q, 20'h00000})) + $signed({20'h00000, s6_plo_q});

    s8_sh     = s7_prod_q[63:21];
    s8_diff   = $signed({s8_sh[42], s8_sh}) - $signed({{4{s7_offc_q[39]}}, s7_offc_q});
    s8_pres_d = {{3{s8_diff[43]}}, s8_diff[43:15]};
  end

  // Advance every stage together; hold all of them on a stall
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s0_dt_q    <= s0_dt_d;
      s0_d1_q    <= pressure_raw_i;

      s1_pts_q   <= s1_pts_d;
      s1_ptco_q  <= s1_ptco_d;
      s1_ptcs_q  <= s1_ptcs_d;
      s1_dtsq_q  <= s1_dtsq_full[47:0];
      s1_d1_q    <= s0_d1_q;

      s2_dtemp_q <= s2_dtemp_d;
      s2_lo_q    <= s2_lo_d;
      s2_off_q   <= s2_off_d;
      s2_sens_q  <= s2_sens_d;
      s2_t2_q    <= s2_t2_d;
      s2_d1_q    <= s1_d1_q;

      s3_sq_q    <= s3_sq_full[34:0];
      s3_lsq_q   <= s3_lsq_full[34:0];
      s3_temp_q  <= s3_temp_d;
      s3_low_q   <= s2_dtemp_q[17];
      s3_cold_q  <= s2_lo_q[18];
      s3_off_q   <= s2_off_q;
      s3_sens_q  <= s2_sens_q;
      s3_d1_q    <= s2_d1_q;

      s4_off2_q  <= s4_off2_d;
      s4_sens2_q <= s4_sens2_d;
      s4_temp_q  <= s3_temp_q;
      s4_off_q   <= s3_off_q;
      s4_sens_q  <= s3_sens_q;
      s4_d1_q    <= s3_d1_q;

      s5_offc_q  <= s4_off_q - $signed(s4_off2_q);
      s5_sensc_q <= s4_sens_q - $signed(s4_sens2_q);
      s5_temp_q  <= s4_temp_q;
      s5_d1_q    <= s4_d1_q;

      s6_plo_q   <= s5_sensc_q[19:0] * s5_d1_q;
      s6_phi_q   <= s6_phi_d;
      s6_offc_q  <= s5_offc_q;
      s6_temp_q  <= s5_temp_q;

      s7_prod_q  <= s7_prod_d;
      s7_offc_q  <= s6_offc_q;
      s7_temp_q  <= s6_temp_q;

      s8_pres_q  <= s8_pres_d;
      s8_temp_q  <= OutW'(s7_temp_q);
    end
  end

  assign out_valid_o   = vld_q[NStages-1];
  assign pressure_o    = s8_pres_q;
  assign temperature_o = s8_temp_q;

  // An accepted transfer always lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted input lost at pipeline entry");

  // A stall freezes the whole valid chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(vld_q))
    else $error("valid chain moved during a stall");

  // An item in the last internal stage reaches the output when the pipe moves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_en && vld_q[NStages-2] |=> out_valid_o)
    else $error("item dropped before the output register");

endmodule

[test/pressure_temp_compensation_unit_test.sv]
// Self-checking testbench for the pressure and temperature compensation pipeline.
module pressure_temp_compensation_unit_test
  import ptc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgAddrW-1:0] RegUnusedLo = 3'd6;
  localparam logic [CfgAddrW-1:0] RegUnusedHi = 3'd7;
  localparam logic [RawW-1:0]     RawMax      = '1;
  localparam logic [CoeffW-1:0]   CoeffMax    = '1;
  localparam int                  HoldCycles  = 200;

  typedef struct packed {
    logic signed [OutW-1:0] pressure;
    logic signed [OutW-1:0] temperature;
  } reading_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgAddrW-1:0]    cfg_addr_i = '0;
  logic [CoeffW-1:0]      cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [RawW-1:0]        pressure_raw_i = '0;
  logic [RawW-1:0]        temp_raw_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic signed [OutW-1:0] pressure_o;
  logic signed [OutW-1:0] temperature_o;

  ptc_coeff_t cal_words;
  reading_t   pending_readings[$];
  reading_t   oldest_reading;
  int         error_count = 0;
  int         samples_sent = 0;
  int         readings_seen = 0;
  int         cal_writes = 0;
  int         burst_left = 0;
  bit         sender_gaps = 1'b0;
  bit         receiver_stalls = 1'b0;
  bit         hold_req = 1'b0;
  int         hold_left = 0;
  logic [15:0] stall_mask = '0;
  int         stall_phase = 0;

  pressure_temp_compensation_unit dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_addr_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .pressure_raw_i,
    .temp_raw_i,
    .out_valid_o,
    .out_ready_i,
    .pressure_o,
    .temperature_o
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #4_000_000;
    $display("pressure_temp_compensation_unit_test NOT OK");
    $finish;
  end

  // Second-order compensation of one raw pair with the current calibration words.
  function automatic reading_t compensate_sample(input logic [RawW-1:0] p_raw,
                                                 input logic [RawW-1:0] t_raw);
    longint d1, d2, dt, tc, off, sens, t2, off2, sens2, dtemp, sq, lo, pr;
    reading_t r;
    d1 = longint'({40'd0, p_raw});
    d2 = longint'({40'd0, t_raw});
    dt = d2 - longint'({48'd0, cal_words.tref}) * 256;
    tc = 2000 + ((dt * longint'({48'd0, cal_words.tempsens})) >>> 23);
    off = longint'({48'd0, cal_words.offset}) * 65536
        + ((longint'({48'd0, cal_words.tco}) * dt) >>> 7);
    sens = longint'({48'd0, cal_words.sens}) * 32768
         + ((longint'({48'd0, cal_words.tcs}) * dt) >>> 8);
    dtemp = tc - 2000;
    sq = dtemp * dtemp;
    if (tc >= 2000) begin
      t2 = (7 * dt * dt) >>> 37;
      off2 = sq >>> 4;
      sens2 = 0;
    end else begin
      t2 = (3 * dt * dt) >>> 33;
      off2 = (3 * sq) >>> 1;
      sens2 = (5 * sq) >>> 3;
      // very cold band adds a further correction
      if (tc < -1500) begin
        lo = tc + 1500;
        off2 += 7 * lo * lo;
        sens2 += 4 * lo * lo;
      end
    end
    tc -= t2;
    off -= off2;
    sens -= sens2;
    pr = (((d1 * sens) >>> 21) - off) >>> 15;
    r.pressure = pr[OutW-1:0];
    r.temperature = tc[OutW-1:0];
    return r;
  endfunction

  // Check every result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      readings_seen++;
      if (pending_readings.size() == 0) begin
        $error("unexpected result: pressure %0d temperature %0d", pressure_o, temperature_o);
        error_count++;
      end else begin
        oldest_reading = pending_readings.pop_front();
        if (pressure_o !== oldest_reading.pressure) begin
          $error("pressure: expected %0d, got %0d", oldest_reading.pressure, pressure_o);
          error_count++;
        end
        if (temperature_o !== oldest_reading.temperature) begin
          $error("temperature: expected %0d, got %0d", oldest_reading.temperature,
                 temperature_o);
          error_count++;
        end
      end
    end
  end

  // Receiver: stall pattern of its own, plus a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
    end
    if (stall_phase == 0) begin
      case ($urandom_range(0, 3))
        0: stall_mask = '0;
        1: stall_mask = 16'($urandom);
        2: stall_mask = 16'($urandom & $urandom);
        default: stall_mask = 16'($urandom | $urandom);
      endcase
    end
    stall_phase = (stall_phase + 1) % 16;
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i = 1'b0;
    end else if (receiver_stalls) begin
      out_ready_i = ~stall_mask[stall_phase];
    end else begin
      out_ready_i = 1'b1;
    end
  end

  task automatic send_sample(input logic [RawW-1:0] p_raw, input logic [RawW-1:0] t_raw);
    int gap;
    if (burst_left == 0) begin
      gap = sender_gaps ? $urandom_range(0, 6) : 0;
      burst_left = $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    pressure_raw_i = p_raw;
    temp_raw_i = t_raw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_readings.push_back(compensate_sample(p_raw, t_raw));
    samples_sent++;
  endtask

  // Drop valid and wait until every predicted result has come out.
  task automatic drain_pipeline();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cal(input logic [CfgAddrW-1:0] idx, input logic [CoeffW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_addr_i = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      RegSens:     cal_words.sens = val;
      RegOffset:   cal_words.offset = val;
      RegTcs:      cal_words.tcs = val;
      RegTco:      cal_words.tco = val;
      RegTref:     cal_words.tref = val;
      RegTempsens: cal_words.tempsens = val;
      default: ;
    endcase
    cal_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic load_cal(input ptc_coeff_t c);
    drain_pipeline();
    write_cal(RegSens, c.sens);
    write_cal(RegOffset, c.offset);
    write_cal(RegTcs, c.tcs);
    write_cal(RegTco, c.tco);
    write_cal(RegTref, c.tref);
    write_cal(RegTempsens, c.tempsens);
  endtask

  task automatic test_reset_values();
    send_sample('0, '0);
    send_sample(RawMax, RawMax);
    send_sample(24'h5A5A5A, 24'hA5A5A5);
    drain_pipeline();
  endtask

  // Walk the band boundaries: with tempsens 8192 a TEMP step is 1024 counts of dT.
  task automatic test_band_edges();
    ptc_coeff_t c;
    logic [RawW-1:0] t_ref;
    c = '{sens: 16'd46372, offset: 16'd43981, tcs: 16'd29059, tco: 16'd27842,
          tref: 16'h8000, tempsens: 16'd8192};
    load_cal(c);
    t_ref = 24'h800000;
    send_sample(24'd4311742, t_ref);
    send_sample(24'd4311742, t_ref - 1);
    send_sample(24'd4311742, t_ref + 1024);
    send_sample(24'd4311742, t_ref - 24'd3584000);
    send_sample(24'd4311742, t_ref - 24'd3584001);
    send_sample(RawMax, '0);
    send_sample('0, RawMax);
    send_sample(RawMax, RawMax);
    send_sample('0, '0);
    drain_pipeline();
  endtask

  task automatic test_register_extremes();
    ptc_coeff_t c;
    c = '0;
    load_cal(c);
    send_sample(RawMax, RawMax);
    send_sample('0, RawMax);
    c = {6{CoeffMax}};
    load_cal(c);
    send_sample(RawMax, RawMax);
    send_sample(RawMax, '0);
    send_sample('0, 24'hFFFF00);
    // unmapped indexes must leave the calibration words alone
    drain_pipeline();
    write_cal(RegUnusedLo, 16'h1234);
    write_cal(RegUnusedHi, 16'h0000);
    send_sample(24'h123456, 24'h654321);
    send_sample(RawMax, 24'hFFFF00);
    drain_pipeline();
  endtask

  task automatic test_random_traffic();
    ptc_coeff_t c;
    logic [CoeffW-1:0] w [6];
    int center;
    int t_val;
    for (int ph = 0; ph < 6; ph++) begin
      for (int k = 0; k < 6; k++) begin
        case ($urandom_range(0, 5))
          0: w[k] = '0;
          1: w[k] = CoeffMax;
          default: w[k] = 16'($urandom);
        endcase
      end
      c = '{sens: w[0], offset: w[1], tcs: w[2], tco: w[3], tref: w[4], tempsens: w[5]};
      load_cal(c);
      sender_gaps = (ph != 0) && ($urandom_range(0, 3) != 0);
      receiver_stalls = (ph != 0) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 150; i++) begin
        if ($urandom_range(0, 2) == 0) begin
          // cluster around the reference to exercise the warm and cool bands
          center = int'({8'd0, cal_words.tref}) * 256;
          t_val = center + int'($urandom_range(0, 2097152)) - 1048576;
          if (t_val < 0) t_val = 0;
          if (t_val > int'(RawMax)) t_val = int'(RawMax);
          send_sample(24'($urandom), 24'(t_val));
        end else begin
          send_sample(24'($urandom), 24'($urandom));
        end
      end
    end
    drain_pipeline();
  endtask

  task automatic test_backpressure();
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 60; i++) send_sample(24'($urandom), 24'($urandom));
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    for (int i = 0; i < 40; i++) send_sample(24'($urandom), 24'($urandom));
    drain_pipeline();
  endtask

  initial begin
    cal_words = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_values();
    test_band_edges();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();
    drain_pipeline();
    repeat (2 * NStages) @(posedge clk_i);
    $display("covered %0d sample pairs and %0d results, %0d calibration writes,",
             samples_sent, readings_seen, cal_writes);
    $display("all three temperature bands, register extremes and a full-pipeline stall");
    if (error_count == 0 && pending_readings.size() == 0) begin
      $display("pressure_temp_compensation_unit_test OK");
    end else begin
      $display("pressure_temp_compensation_unit_test NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
hdl/ptc_pkg.sv
hdl/ptc_regs.sv
hdl/pressure_temp_compensation_unit.sv
test/pressure_temp_compensation_unit_test.sv
